[hdl/smc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_pkg: shared types and constants of the substring match counter
// Register indexes, fixed field widths and the per-byte control group that
// travels between the window and the tracker.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int BYTE_BITS     = 8;
    localparam int REG_BYTES     = 16;  // pattern bytes that the registers can hold
    localparam int LEN_BITS      = 5;   // pattern_length register width
    localparam int NTH_BITS      = 16;  // nth_match register width
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2,
        REG_NTH_MATCH    = 2'd3
    } cfg_index_t;

    // Control for one byte moving from the input register to the result register.
    typedef struct packed {
        logic advance;    // the byte is processed this cycle
        logic last;       // the byte ends the text
        logic window_ok;  // every used pattern byte equals its window byte
    } smc_step_t;

endpackage

[hdl/smc_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_window: sliding byte window and parallel pattern compare
// Shifts the incoming byte into the window and compares the newest bytes
// against the pattern, aligned so that the last pattern byte meets the newest.
// ----------------------------------------------------------------------------
module smc_window import smc_pkg::*; #(
    parameter int PATTERN_BYTES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          last,
    input  logic [BYTE_BITS-1:0]          text_byte,
    input  logic [2*CFG_DATA_BITS-1:0]    pattern,
    input  logic [LEN_BITS-1:0]           pattern_length,
    output logic [LEN_BITS-1:0]           eff_len,
    output logic                          window_ok
);

    localparam int MaxLen = (PATTERN_BYTES < REG_BYTES) ? PATTERN_BYTES : REG_BYTES;

    logic [PATTERN_BYTES-1:0][BYTE_BITS-1:0] win_reg;
    logic [PATTERN_BYTES-1:0][BYTE_BITS-1:0] win_next;
    logic [REG_BYTES-1:0][BYTE_BITS-1:0]     pat_bytes;
    logic [PATTERN_BYTES-1:0]                byte_ok;

    assign pat_bytes = pattern;

    always_comb begin
        if (pattern_length > LEN_BITS'(MaxLen)) begin
            eff_len = LEN_BITS'(MaxLen);
        end else begin
            eff_len = pattern_length;
        end
    end

    always_comb begin
        win_next[0] = text_byte;
        for (int j = 1; j < PATTERN_BYTES; j++) begin
            win_next[j] = win_reg[j-1];
        end
    end

    // Window byte j pairs with pattern byte eff_len-1-j; bytes past the length pass.
    always_comb begin
        for (int j = 0; j < PATTERN_BYTES; j++) begin
            if (j < int'(eff_len)) begin
                byte_ok[j] = (win_next[j] == pat_bytes[4'(int'(eff_len) - 1 - j)]);
            end else begin
                byte_ok[j] = 1'b1;
            end
        end
    end

    assign window_ok = &byte_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (advance) begin
            if (last) begin
                win_reg <= '0;
            end else begin
                win_reg <= win_next;
            end
        end
    end

endmodule

[hdl/smc_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_tracker: position, match count and nth-match tracking
// Decides whether a match ends at the current byte and produces the result
// fields; all per-text state clears after the last byte.
// ----------------------------------------------------------------------------
module smc_tracker import smc_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  smc_step_t                 step,
    input  logic [LEN_BITS-1:0]       eff_len,
    input  logic [NTH_BITS-1:0]       nth_match,
    output logic                      match_here,
    output logic [POSITION_BITS-1:0]  match_start,
    output logic [POSITION_BITS-1:0]  match_total,
    output logic                      nth_found,
    output logic [POSITION_BITS-1:0]  nth_position,
    output logic                      position_overflow
);

    localparam int PosW1 = POSITION_BITS + 1;

    logic [POSITION_BITS-1:0] pos_reg,   pos_next;
    logic [POSITION_BITS-1:0] tally_reg, tally_next;
    logic                     found_reg, found_next;
    logic [POSITION_BITS-1:0] fstart_reg, fstart_next;
    logic                     ovf_reg,   ovf_next;
    logic [NTH_BITS-1:0]      need;
    logic                     in_text;

    assign need    = (nth_match == '0) ? NTH_BITS'(1) : nth_match;
    // Before the window fills, a match must not reach back past the text start.
    assign in_text = ovf_reg || ((PosW1'(pos_reg) + PosW1'(1)) >= PosW1'(eff_len));
    assign match_here = step.window_ok && in_text;

    always_comb begin
        if (!match_here) begin
            match_start = '0;
        end else if (eff_len == '0) begin
            match_start = pos_reg;
        end else begin
            match_start = pos_reg + POSITION_BITS'(1) - POSITION_BITS'(eff_len);
        end
    end

    always_comb begin
        tally_next  = tally_reg;
        found_next  = found_reg;
        fstart_next = fstart_reg;
        if (match_here) begin
            if (tally_reg != '1) begin
                tally_next = tally_reg + POSITION_BITS'(1);
            end
            if (!found_reg && (32'(tally_next) >= 32'(need))) begin
                found_next  = 1'b1;
                fstart_next = match_start;
            end
        end
        ovf_next = ovf_reg || (pos_reg == '1);
        pos_next = pos_reg + POSITION_BITS'(1);
    end

    assign match_total       = tally_next;
    assign nth_found         = found_next;
    assign nth_position      = found_next ? fstart_next : '0;
    assign position_overflow = ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            tally_reg  <= '0;
            found_reg  <= 1'b0;
            fstart_reg <= '0;
            ovf_reg    <= 1'b0;
        end else if (step.advance) begin
            if (step.last) begin
                pos_reg    <= '0;
                tally_reg  <= '0;
                found_reg  <= 1'b0;
                fstart_reg <= '0;
                ovf_reg    <= 1'b0;
            end else begin
                pos_reg    <= pos_next;
                tally_reg  <= tally_next;
                found_reg  <= found_next;
                fstart_reg <= fstart_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

endmodule

[hdl/substring_match_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_match_counter: streaming substring search with match counting
// Searches a byte stream for a configured pattern and counts the matches.
// ----------------------------------------------------------------------------
// Usage:
// The text enters one byte per transfer on the s_ channel; s_tlast marks the
// final byte of a text. Each byte yields exactly one result transfer on the
// m_ channel, in order, with m_tlast echoing the input's last marker.
// A taken byte is held in the input register, where it is compared and
// counted, and its result is then captured in the result register, which
// drives m_tvalid. The pattern compare is fully parallel over the window, so
// one byte per clock cycle is sustained while the receiver does not stall.
// When the receiver stalls, the result register holds its transfer and the
// input register still takes one more byte; s_tready then drops until the
// result is taken. Reset (aresetn low, synchronous) empties both registers,
// clears the window and all per-text counters, and returns the configuration
// registers to an empty pattern with the first match requested.
// The configuration port is meant to be written only while no text is in flight.
// ----------------------------------------------------------------------------
module substring_match_counter import smc_pkg::*; #(
    parameter int PATTERN_BYTES = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write port.
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]     cfg_wr_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_wr_data,
    // Text input.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [BYTE_BITS-1:0]        s_tdata,   // [7:0] text_byte
    input  logic                        s_tlast,   // last_byte
    // Results.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // From bit 0 up: match_here, match_start, match_total, nth_found,
    // nth_position, position_overflow, then zero fill.
    output logic [((3*POSITION_BITS+3+7)/8)*8-1:0] m_tdata,
    output logic                        m_tlast    // text_end
);

    localparam int OutBits = 3*POSITION_BITS + 3;
    localparam int OutW    = ((OutBits + 7) / 8) * 8;

    // Configuration registers.
    logic [CFG_DATA_BITS-1:0] pat_low_reg;
    logic [CFG_DATA_BITS-1:0] pat_high_reg;
    logic [LEN_BITS-1:0]      pat_len_reg;
    logic [NTH_BITS-1:0]      nth_reg;

    // Input register.
    logic                     in_valid_reg, in_valid_next;
    logic [BYTE_BITS-1:0]     in_byte_reg;
    logic                     in_last_reg;

    // Result register.
    logic                     out_valid_reg, out_valid_next;
    logic                     res_here_reg;
    logic [POSITION_BITS-1:0] res_start_reg;
    logic [POSITION_BITS-1:0] res_total_reg;
    logic                     res_found_reg;
    logic [POSITION_BITS-1:0] res_nthpos_reg;
    logic                     res_ovf_reg;
    logic                     res_last_reg;

    logic                     s_accept;
    logic                     advance;
    logic [LEN_BITS-1:0]      eff_len;
    logic                     window_ok;
    smc_step_t                step;

    logic                     match_here;
    logic [POSITION_BITS-1:0] match_start;
    logic [POSITION_BITS-1:0] match_total;
    logic                     nth_found;
    logic [POSITION_BITS-1:0] nth_position;
    logic                     position_overflow;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            nth_reg      <= NTH_BITS'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_wr_index))
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_wr_data;
                REG_PATTERN_HIGH: pat_high_reg <= cfg_wr_data;
                REG_PATTERN_LEN:  pat_len_reg  <= cfg_wr_data[LEN_BITS-1:0];
                REG_NTH_MATCH:    nth_reg      <= cfg_wr_data[NTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // A byte moves on when the result register is empty or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance) begin
            res_here_reg   <= match_here;
            res_start_reg  <= match_start;
            res_total_reg  <= match_total;
            res_found_reg  <= nth_found;
            res_nthpos_reg <= nth_position;
            res_ovf_reg    <= position_overflow;
            res_last_reg   <= in_last_reg;
        end
    end

    smc_window #(
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .last           (in_last_reg),
        .text_byte      (in_byte_reg),
        .pattern        ({pat_high_reg, pat_low_reg}),
        .pattern_length (pat_len_reg),
        .eff_len        (eff_len),
        .window_ok      (window_ok)
    );

    assign step.advance   = advance;
    assign step.last      = in_last_reg;
    assign step.window_ok = window_ok;

    smc_tracker #(
        .POSITION_BITS (POSITION_BITS)
    ) u_tracker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step              (step),
        .eff_len           (eff_len),
        .nth_match         (nth_reg),
        .match_here        (match_here),
        .match_start       (match_start),
        .match_total       (match_total),
        .nth_found         (nth_found),
        .nth_position      (nth_position),
        .position_overflow (position_overflow)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = res_last_reg;
    assign m_tdata  = OutW'({res_ovf_reg, res_nthpos_reg, res_found_reg,
                             res_total_reg, res_start_reg, res_here_reg});

    // A processed byte always leaves a result behind.
    a_advance_fills_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed byte did not produce a result");

    // A match in the result implies a nonzero running count.
    a_match_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_here_reg) |-> (res_total_reg != '0))
        else $error("match reported with zero count");

    // The nth match is only reported found once the count has reached it.
    a_nth_after_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_found_reg) |->
            ((32'(res_total_reg) >= 32'(nth_reg)) || (nth_reg == '0)))
        else $error("nth match found before the count reached it");

    // A stalled result is not overwritten by the next byte.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> $stable(res_total_reg) && $stable(res_last_reg))
        else $error("result register changed while stalled");

endmodule

[verif/substring_match_counter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_match_counter_tb: self-checking bench for the substring matcher
// Streams texts through the block under many pattern settings, predicts the
// report of every byte, and compares each returned report field by field.
// ----------------------------------------------------------------------------
module substring_match_counter_tb;
    import smc_pkg::*;

    localparam int POS_BITS    = 16;
    localparam int RESULT_BITS = ((3*POS_BITS+3+7)/8)*8;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef bit [BYTE_BITS-1:0] byte_q_t[$];

    // One report as the block returns it for one text byte.
    typedef struct {
        bit                match_here;
        bit [POS_BITS-1:0] match_start;
        bit [POS_BITS-1:0] match_total;
        bit                nth_found;
        bit [POS_BITS-1:0] nth_position;
        bit                position_overflow;
        bit                text_end;
    } byte_report_t;

    // Tracks the pattern registers and the per-text search state, works out
    // the report of every accepted byte and checks the returned reports in order.
    class match_tracker;
        bit [CFG_DATA_BITS-1:0] pat_low;
        bit [CFG_DATA_BITS-1:0] pat_high;
        bit [LEN_BITS-1:0]      pat_len;
        bit [NTH_BITS-1:0]      nth_req;
        bit [BYTE_BITS-1:0]     window [REG_BYTES];
        bit [POS_BITS-1:0]      position;
        bit [POS_BITS-1:0]      tally;
        bit [POS_BITS-1:0]      found_pos;
        bit                     found;
        bit                     wrapped;
        byte_report_t           expected_reports[$];
        int unsigned            mismatch_count;

        function new();
            pat_low  = '0;
            pat_high = '0;
            pat_len  = '0;
            nth_req  = NTH_BITS'(1);
            mismatch_count = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (window[i]) window[i] = '0;
            position  = '0;
            tally     = '0;
            found_pos = '0;
            found     = 1'b0;
            wrapped   = 1'b0;
        endfunction

        function bit [BYTE_BITS-1:0] pattern_byte(int unsigned k);
            return (k < 8) ? pat_low[8*k +: 8] : pat_high[8*(k-8) +: 8];
        endfunction

        function void set_reg(cfg_index_t idx, bit [CFG_DATA_BITS-1:0] value);
            case (idx)
                REG_PATTERN_LOW:  pat_low  = value;
                REG_PATTERN_HIGH: pat_high = value;
                REG_PATTERN_LEN:  pat_len  = value[LEN_BITS-1:0];
                REG_NTH_MATCH:    nth_req  = value[NTH_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void note_byte(bit [BYTE_BITS-1:0] text_byte, bit last);
            byte_report_t      rep;
            int unsigned       len;
            bit [NTH_BITS-1:0] need;
            bit                hit;
            // Lengths past the register capacity use all sixteen bytes.
            len = (pat_len > REG_BYTES) ? REG_BYTES : pat_len;
            for (int k = REG_BYTES - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = text_byte;
            // A match has to fit inside the text, unless the position already wrapped.
            hit = wrapped || (position + 1 >= len);
            for (int unsigned k = 0; k < len; k++) begin
                if (window[len-1-k] != pattern_byte(k)) hit = 1'b0;
            end
            rep.match_start = '0;
            if (hit) begin
                rep.match_start = (len == 0) ? position : POS_BITS'(position + 1 - len);
                if (tally != '1) tally++;
                need = (nth_req == '0) ? NTH_BITS'(1) : nth_req;
                if (!found && tally >= need) begin
                    found     = 1'b1;
                    found_pos = rep.match_start;
                end
            end
            rep.match_here        = hit;
            rep.match_total       = tally;
            rep.nth_found         = found;
            rep.nth_position      = found ? found_pos : '0;
            rep.position_overflow = wrapped;
            rep.text_end          = last;
            expected_reports.push_back(rep);
            if (position == '1) wrapped = 1'b1;
            position++;
            if (last) clear_text();
        endfunction

        function void compare(string name, logic [POS_BITS-1:0] want,
                              logic [POS_BITS-1:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(logic [RESULT_BITS-1:0] data, logic last);
            byte_report_t want;
            if (expected_reports.size() == 0) begin
                $error("result transfer with no text byte pending");
                mismatch_count++;
                return;
            end
            want = expected_reports.pop_front();
            compare("match_here",        want.match_here,        data[0]);
            compare("match_start",       want.match_start,       data[1 +: POS_BITS]);
            compare("match_total",       want.match_total,       data[1+POS_BITS +: POS_BITS]);
            compare("nth_found",         want.nth_found,         data[1+2*POS_BITS]);
            compare("nth_position",      want.nth_position,      data[2+2*POS_BITS +: POS_BITS]);
            compare("position_overflow", want.position_overflow, data[2+3*POS_BITS]);
            compare("text_end",          want.text_end,          last);
        endfunction
    endclass

    // Every input of the block holds a known value from time zero on.
    logic                     aclk         = 1'b0;
    logic                     aresetn      = 1'b0;
    logic                     cfg_wr_en    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data  = '0;
    logic                     s_tvalid     = 1'b0;
    logic                     s_tready;
    logic [BYTE_BITS-1:0]     s_tdata      = '0;   // [7:0] text_byte
    logic                     s_tlast      = 1'b0; // last_byte
    logic                     m_tvalid;
    logic                     m_tready     = 1'b0;
    // From bit 0 up: match_here, match_start, match_total, nth_found,
    // nth_position, position_overflow, then zero fill.
    logic [RESULT_BITS-1:0]   m_tdata;
    logic                     m_tlast;             // text_end

    match_tracker tracker;
    int unsigned  max_idle;     // longest gap or stall either side may draw
    int unsigned  cycle_count = 0;

    substring_match_counter #(
        .PATTERN_BYTES (REG_BYTES),
        .POSITION_BITS (POS_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one byte after a random gap and returns at the edge where the
    // transfer happens. All signals are read right after the edge, so they
    // still show the values the block saw at that edge. A zero gap keeps
    // s_tvalid high from one byte to the next, giving back-to-back transfers.
    task automatic send_byte(bit [BYTE_BITS-1:0] text_byte, bit last);
        int unsigned gap;
        gap = $urandom_range(0, max_idle);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= text_byte;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_byte(text_byte, last);
    endtask

    // Sends a whole text with the final byte marked as last.
    task automatic send_text(byte_q_t text);
        foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    endtask

    // Stops offering bytes and waits until every report has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.expected_reports.size() != 0) @(posedge aclk);
    endtask

    // Writes all four registers back to back once the block is idle. The
    // length and nth values may go in with junk in their upper bits on purpose,
    // since the block keeps only the low bits.
    task automatic load_config(bit [CFG_DATA_BITS-1:0] low, bit [CFG_DATA_BITS-1:0] high,
                               bit [CFG_DATA_BITS-1:0] len_raw,
                               bit [CFG_DATA_BITS-1:0] nth_raw);
        bit [CFG_DATA_BITS-1:0] values [4];
        cfg_index_t             idx;
        values = '{low, high, len_raw, nth_raw};
        wait_idle();
        idx = idx.first();
        do begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= idx;
            cfg_wr_data  <= values[int'(idx)];
            @(posedge aclk);
            tracker.set_reg(idx, values[int'(idx)]);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: stalls a random number of cycles before every report,
    // then checks the report at the edge where its transfer happens.
    task automatic collect_results();
        int unsigned stall;
        forever begin
            stall = $urandom_range(0, max_idle);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            tracker.check_result(m_tdata, m_tlast);
        end
    endtask

    // Builds a text that is mostly copies of the current pattern mixed with
    // bytes of a small alphabet, so that matches and near misses are common,
    // plus some bytes from the full range as noise.
    function automatic byte_q_t random_text(int unsigned size, bit [BYTE_BITS-1:0] alpha [4],
                                            int unsigned alpha_n, int unsigned pat_n);
        byte_q_t text;
        while (text.size() < size) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    for (int unsigned k = 0; k < pat_n; k++)
                        text.push_back(tracker.pattern_byte(k));
                end
                4:       text.push_back(BYTE_BITS'($urandom_range(0, 255)));
                default: text.push_back(alpha[$urandom_range(0, alpha_n - 1)]);
            endcase
        end
        while (text.size() > size) void'(text.pop_back());
        return text;
    endfunction

    initial begin
        byte_q_t                text;
        bit [BYTE_BITS-1:0]     alpha [4];
        bit [BYTE_BITS-1:0]     pick;
        bit [CFG_DATA_BITS-1:0] low, high, len_raw, nth_raw;
        int unsigned            alpha_n, len_pick, pat_n, phase_bytes;

        tracker  = new();
        max_idle = 3;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            collect_results();
        join_none

        // Directed texts. The first runs on the reset settings: an empty
        // pattern, so every byte matches at its own position.
        text = {8'h00, 8'hFF};
        send_text(text);

        // Pattern "AA" looking for the second match: overlapping matches count.
        load_config(64'h4141, '0, 64'd2, 64'd2);
        text = {8'h41, 8'h41, 8'h41, 8'h41};
        send_text(text);

        // Three zero bytes against a zero-filled window: the first two bytes
        // cannot match because the match would start before the text. An nth
        // value of zero asks for the first match.
        load_config('0, '0, 64'd3, 64'd0);
        text = {8'h00, 8'h00, 8'h00, 8'h00};
        send_text(text);

        // Length field all ones reads as 31 and is clipped to sixteen bytes;
        // the nth field keeps only its low bits.
        low  = 64'hC33C_0FF0_A55A_00FF;
        high = 64'h3CC3_F00F_5AA5_FF00;
        load_config(low, high, '1, 64'hFFFF_FFFF_FFFF_0001);
        text.delete();
        for (int unsigned k = 0; k < REG_BYTES; k++) text.push_back(tracker.pattern_byte(k));
        send_text(text);

        // Random phases, each with fresh settings. Every fourth phase runs
        // without gaps or stalls.
        for (int phase = 0; phase < 12; phase++) begin
            alpha_n = (phase % 3 == 0) ? 1 : $urandom_range(2, 4);
            foreach (alpha[i]) alpha[i] = BYTE_BITS'($urandom_range(0, 255));
            for (int k = 0; k < REG_BYTES; k++) begin
                pick = (phase % 4 == 1) ? BYTE_BITS'($urandom_range(0, 255))
                                        : alpha[$urandom_range(0, alpha_n - 1)];
                if (k < 8) low[8*k +: 8] = pick;
                else       high[8*(k-8) +: 8] = pick;
            end
            case ($urandom_range(0, 5))
                0:       len_pick = 0;
                1:       len_pick = 1;
                2:       len_pick = REG_BYTES;
                3:       len_pick = $urandom_range(REG_BYTES + 1, 31);
                default: len_pick = $urandom_range(2, 8);
            endcase
            len_raw = {$urandom, $urandom};
            len_raw[LEN_BITS-1:0] = LEN_BITS'(len_pick);
            nth_raw = {$urandom, $urandom};
            case ($urandom_range(0, 4))
                0:       nth_raw[NTH_BITS-1:0] = '0;
                1:       nth_raw[NTH_BITS-1:0] = NTH_BITS'(1);
                2:       nth_raw[NTH_BITS-1:0] = '1;
                3:       ;
                default: nth_raw[NTH_BITS-1:0] = NTH_BITS'($urandom_range(2, 6));
            endcase
            max_idle = (phase % 4 == 3) ? 0 : 18;
            load_config(low, high, len_raw, nth_raw);
            pat_n = (len_pick > REG_BYTES) ? REG_BYTES : len_pick;
            phase_bytes = 0;
            while (phase_bytes < 36) begin
                text = random_text($urandom_range(1, 40), alpha, alpha_n, pat_n);
                phase_bytes += text.size();
                send_text(text);
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (tracker.mismatch_count == 0 && tracker.expected_reports.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
